@@ rtl/dpw_pkg.sv @@
// ----------------------------------------------------------------------------
// dpw_pkg
// Types, register map and saturation helpers for the depth pixel to world
// point core.
// ----------------------------------------------------------------------------
package dpw_pkg;

  localparam int CAM_W = 46;   // camera coordinate width, signed
  localparam int COLOR_W = 24; // blue, green, red bytes, blue lowest

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE_RECIP = 3'd0,
    REG_PRINCIPAL_POINT   = 3'd1,
    REG_FOCAL_RECIP       = 3'd2,
    REG_ROT_ROW0          = 3'd3,
    REG_ROT_ROW1          = 3'd4,
    REG_ROT_ROW2          = 3'd5,
    REG_TRANSLATION_XY    = 3'd6,
    REG_TRANSLATION_Z     = 3'd7
  } cfg_reg_t;

  localparam logic [31:0] RST_DEPTH_SCALE_RECIP = 32'd16777;
  localparam logic [31:0] RST_PRINCIPAL_POINT   = 32'd0;
  localparam logic [63:0] RST_FOCAL_RECIP       = 64'd0;
  localparam logic [47:0] RST_ROT_ROW0          = 48'h0000_0000_4000;
  localparam logic [47:0] RST_ROT_ROW1          = 48'h0000_4000_0000;
  localparam logic [47:0] RST_ROT_ROW2          = 48'h4000_0000_0000;
  localparam logic [63:0] RST_TRANSLATION_XY    = 64'd0;
  localparam logic [31:0] RST_TRANSLATION_Z     = 32'd0;

  typedef struct packed {
    logic [31:0]      depth_scale_recip;
    logic [31:0]      principal_point;
    logic [63:0]      focal_recip;
    logic [2:0][47:0] rot_row;
    logic [63:0]      translation_xy;
    logic [31:0]      translation_z;
  } cfg_t;

  // clamp to signed 46 bits
  function automatic logic [CAM_W-1:0] sat46(logic signed [62:0] v);
    logic [CAM_W-1:0] res;
    if ((&v[62:CAM_W-1]) || !(|v[62:CAM_W-1])) begin
      res = v[CAM_W-1:0];
    end else if (v[62]) begin
      res = {1'b1, {(CAM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(CAM_W-1){1'b1}}};
    end
    return res;
  endfunction

  // clamp to signed 32 bits
  function automatic logic [31:0] sat32(logic signed [63:0] v);
    logic [31:0] res;
    if ((&v[63:31]) || !(|v[63:31])) begin
      res = v[31:0];
    end else if (v[63]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

@@ rtl/dpw_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dpw_cfg_regs
// APB register file holding the camera intrinsics and the pose.
// ----------------------------------------------------------------------------
module dpw_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output dpw_pkg::cfg_t cfg
);

  dpw_pkg::cfg_t      cfg_r;
  dpw_pkg::cfg_reg_t  idx;
  logic               wr_en;

  assign idx    = dpw_pkg::cfg_reg_t'(paddr[5:3]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_scale_recip <= dpw_pkg::RST_DEPTH_SCALE_RECIP;
      cfg_r.principal_point   <= dpw_pkg::RST_PRINCIPAL_POINT;
      cfg_r.focal_recip       <= dpw_pkg::RST_FOCAL_RECIP;
      cfg_r.rot_row[0]        <= dpw_pkg::RST_ROT_ROW0;
      cfg_r.rot_row[1]        <= dpw_pkg::RST_ROT_ROW1;
      cfg_r.rot_row[2]        <= dpw_pkg::RST_ROT_ROW2;
      cfg_r.translation_xy    <= dpw_pkg::RST_TRANSLATION_XY;
      cfg_r.translation_z     <= dpw_pkg::RST_TRANSLATION_Z;
    end else if (wr_en) begin
      unique case (idx)
        dpw_pkg::REG_DEPTH_SCALE_RECIP: cfg_r.depth_scale_recip <= pwdata[31:0];
        dpw_pkg::REG_PRINCIPAL_POINT:   cfg_r.principal_point   <= pwdata[31:0];
        dpw_pkg::REG_FOCAL_RECIP:       cfg_r.focal_recip       <= pwdata;
        dpw_pkg::REG_ROT_ROW0:          cfg_r.rot_row[0]        <= pwdata[47:0];
        dpw_pkg::REG_ROT_ROW1:          cfg_r.rot_row[1]        <= pwdata[47:0];
        dpw_pkg::REG_ROT_ROW2:          cfg_r.rot_row[2]        <= pwdata[47:0];
        dpw_pkg::REG_TRANSLATION_XY:    cfg_r.translation_xy    <= pwdata;
        dpw_pkg::REG_TRANSLATION_Z:     cfg_r.translation_z     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dpw_pkg::REG_DEPTH_SCALE_RECIP: prdata = 64'(cfg_r.depth_scale_recip);
      dpw_pkg::REG_PRINCIPAL_POINT:   prdata = 64'(cfg_r.principal_point);
      dpw_pkg::REG_FOCAL_RECIP:       prdata = cfg_r.focal_recip;
      dpw_pkg::REG_ROT_ROW0:          prdata = 64'(cfg_r.rot_row[0]);
      dpw_pkg::REG_ROT_ROW1:          prdata = 64'(cfg_r.rot_row[1]);
      dpw_pkg::REG_ROT_ROW2:          prdata = 64'(cfg_r.rot_row[2]);
      dpw_pkg::REG_TRANSLATION_XY:    prdata = cfg_r.translation_xy;
      dpw_pkg::REG_TRANSLATION_Z:     prdata = 64'(cfg_r.translation_z);
      default:                        prdata = 64'd0;
    endcase
  end

endmodule

@@ rtl/dpw_backproj.sv @@
// ----------------------------------------------------------------------------
// dpw_backproj
// Six-stage pinhole back-projection: depth pixel to clamped camera x, y, z.
// ----------------------------------------------------------------------------
module dpw_backproj (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dpw_pkg::cfg_t                       cfg,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic [11:0]                         pixel_col,
  input  logic [11:0]                         pixel_row,
  input  logic [15:0]                         depth_raw,
  input  logic [dpw_pkg::COLOR_W-1:0]         color_in,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output logic [2:0][dpw_pkg::CAM_W-1:0]      cam,
  output logic [dpw_pkg::COLOR_W-1:0]         color_out
);

  localparam int NS = 6;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  assign rdy[NS] = dn_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];

  // a zero-depth word is taken and dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid && (depth_raw != 16'd0);
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---- stage 1: z = (depth * 1/scale + 2^7) >> 8
  logic [47:0] zprod;
  logic [47:0] zsum;
  logic [39:0] z1_r, z2_r, z3_r, z4_r, z5_r, z6_r;
  logic [dpw_pkg::COLOR_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  assign zprod = 48'(depth_raw) * 48'(cfg.depth_scale_recip);
  assign zsum  = zprod + 48'd128;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      z1_r <= zsum[47:8];
      c1_r <= color_in;
    end
    if (rdy[1]) begin z2_r <= z1_r; c2_r <= c1_r; end
    if (rdy[2]) begin z3_r <= z2_r; c3_r <= c2_r; end
    if (rdy[3]) begin z4_r <= z3_r; c4_r <= c3_r; end
    if (rdy[4]) begin z5_r <= z4_r; c5_r <= c4_r; end
    if (rdy[5]) begin z6_r <= z5_r; c6_r <= c5_r; end
  end

  // x lane 0 (column, cx, 1/fx), y lane 1 (row, cy, 1/fy)
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [11:0]               coord;
    logic [15:0]               center;
    logic [31:0]               recip;
    logic signed [16:0]        d_nxt;
    logic signed [16:0]        d1_r;
    logic signed [57:0]        t_nxt;
    logic signed [57:0]        t2_r;
    logic [56:0]               m_nxt;
    logic [56:0]               m3_r;
    logic                      neg3_r, neg4_r, neg5_r;
    logic [56:0]               phi_nxt;
    logic [63:0]               plo_nxt;
    logic [56:0]               phi4_r;
    logic [63:0]               plo4_r;
    logic [64:0]               plo_rnd;
    logic [61:0]               r_nxt;
    logic [61:0]               r5_r;
    logic signed [62:0]        s_nxt;
    logic [dpw_pkg::CAM_W-1:0] c6_r;

    assign coord  = (l == 0) ? pixel_col : pixel_row;
    assign center = cfg.principal_point[16*l +: 16];
    assign recip  = cfg.focal_recip[32*l +: 32];

    // stage 1: offset from the principal point, Q12.4
    assign d_nxt = $signed({1'b0, coord, 4'b0000}) - $signed({1'b0, center});
    // stage 2: offset times z
    assign t_nxt = d1_r * $signed({1'b0, z1_r});
    // stage 3: magnitude and sign
    assign m_nxt = t2_r[57] ? 57'(-t2_r) : t2_r[56:0];
    // stage 4: split magnitude times 1/f
    assign phi_nxt = 57'(m3_r[56:32]) * 57'(recip);
    assign plo_nxt = 64'(m3_r[31:0]) * 64'(recip);
    // stage 5: recombine, round at bit 28
    assign plo_rnd = 65'(plo4_r) + 65'(64'd1 << 27);
    assign r_nxt   = 62'({phi4_r, 4'b0000}) + 62'(plo_rnd[64:28]);
    // stage 6: restore sign, clamp
    assign s_nxt = neg5_r ? -$signed({1'b0, r5_r}) : $signed({1'b0, r5_r});

    always_ff @(posedge clk) begin
      if (rdy[0]) d1_r <= d_nxt;
      if (rdy[1]) t2_r <= t_nxt;
      if (rdy[2]) begin
        m3_r   <= m_nxt;
        neg3_r <= t2_r[57];
      end
      if (rdy[3]) begin
        phi4_r <= phi_nxt;
        plo4_r <= plo_nxt;
        neg4_r <= neg3_r;
      end
      if (rdy[4]) begin
        r5_r   <= r_nxt;
        neg5_r <= neg4_r;
      end
      if (rdy[5]) c6_r <= dpw_pkg::sat46(s_nxt);
    end

    assign cam[l] = c6_r;
  end

  // z is below 2^40, the clamp never bites
  assign cam[2]    = dpw_pkg::CAM_W'(z6_r);
  assign color_out = c6_r;

endmodule

@@ rtl/dpw_pose.sv @@
// ----------------------------------------------------------------------------
// dpw_pose
// Three-stage rigid transform p' = R * p + t with Q16.16 rounding and
// saturation; the last stage is the output register.
// ----------------------------------------------------------------------------
module dpw_pose (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dpw_pkg::cfg_t                  cfg,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [2:0][dpw_pkg::CAM_W-1:0] cam,
  input  logic [dpw_pkg::COLOR_W-1:0]    color_in,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [2:0][31:0]               point,
  output logic [dpw_pkg::COLOR_W-1:0]    color_out
);

  localparam int NS = 3;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;

  assign rdy[NS] = dn_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  logic [dpw_pkg::COLOR_W-1:0] c1_r, c2_r, c3_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) c1_r <= color_in;
    if (rdy[1]) c2_r <= c1_r;
    if (rdy[2]) c3_r <= c2_r;
  end

  assign color_out = c3_r;

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic [31:0]        trans;
    logic signed [61:0] prod_nxt [3];
    logic signed [61:0] prod1_r  [3];
    logic signed [63:0] sum_nxt;
    logic signed [63:0] sum2_r;
    logic signed [63:0] q_nxt;
    logic [31:0]        pt3_r;

    if (r == 2) begin : g_tz
      assign trans = cfg.translation_z;
    end else begin : g_txy
      assign trans = cfg.translation_xy[32*r +: 32];
    end

    // stage 1: one product per rotation entry, Q.30
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign prod_nxt[c] = $signed(cfg.rot_row[r][16*c +: 16]) * $signed(cam[c]);
    end

    // stage 2: row sum plus translation aligned to Q.30, plus half LSB
    assign sum_nxt = 64'(prod1_r[0]) + 64'(prod1_r[1]) + 64'(prod1_r[2])
                   + (64'($signed(trans)) <<< 14) + 64'sd8192;

    // stage 3: floor shift to Q16.16, saturate
    assign q_nxt = sum2_r >>> 14;

    always_ff @(posedge clk) begin
      if (rdy[0]) begin
        for (int c = 0; c < 3; c++) prod1_r[c] <= prod_nxt[c];
      end
      if (rdy[1]) sum2_r <= sum_nxt;
      if (rdy[2]) pt3_r  <= dpw_pkg::sat32(q_nxt);
    end

    assign point[r] = pt3_r;
  end

endmodule

@@ rtl/depth_pixel_to_world_point_core.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core
// Back-projects depth pixels through a pinhole camera and moves the points
// into world coordinates with a configured pose.
//
//   port group  | dir | width | contents
//   in_         | in  | 64    | one depth pixel with its colour
//   out_        | out | 120   | one world point with its colour
//   cfg_        | in  | 64    | APB registers, 8 bytes apart
//
// One word per cycle enters and leaves while out_tready holds high; words pass
// the back-projection pipe, then the pose pipe, which ends in the output reg.
// A zero-depth word is taken and yields no output word.
// Reset clears all stage valid bits and loads register defaults.
// Each stage takes a new word when it is empty or its successor moves, so a
// stalled output only holds the stages that are full.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_core (
  input  logic         clk,
  input  logic         rst_n,
  // pixel_col[11:0], pixel_row[23:12], depth_raw[39:24],
  // blue_in[47:40], green_in[55:48], red_in[63:56]
  input  logic [63:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x[31:0], point_y[63:32], point_z[95:64],
  // blue_out[103:96], green_out[111:104], red_out[119:112]
  output logic [119:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  dpw_pkg::cfg_t                    cfg;
  logic                             bp_valid;
  logic                             bp_ready;
  logic [2:0][dpw_pkg::CAM_W-1:0]   cam;
  logic [dpw_pkg::COLOR_W-1:0]      bp_color;
  logic [2:0][31:0]                 point;
  logic [dpw_pkg::COLOR_W-1:0]      out_color;

  dpw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dpw_backproj u_bp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .pixel_col (in_tdata[11:0]),
    .pixel_row (in_tdata[23:12]),
    .depth_raw (in_tdata[39:24]),
    .color_in  (in_tdata[63:40]),
    .dn_valid  (bp_valid),
    .dn_ready  (bp_ready),
    .cam       (cam),
    .color_out (bp_color)
  );

  dpw_pose u_pose (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .up_valid  (bp_valid),
    .up_ready  (bp_ready),
    .cam       (cam),
    .color_in  (bp_color),
    .dn_valid  (out_tvalid),
    .dn_ready  (out_tready),
    .point     (point),
    .color_out (out_color)
  );

  assign out_tdata = {out_color, point[2], point[1], point[0]};

endmodule

@@ tb/sv/depth_pixel_to_world_point_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core_test
// Self-checking bench for the depth pixel to world point core. A short table
// of corner pixels runs first under reset, saturating, plausible and all-zero register
// settings. Random pixel streams follow under a series of drawn camera and
// pose settings, with random gaps on the pixel side and random stalls on the
// point side. Every output word is compared with a fixed-point model of the
// back-projection and pose transform, or for typed table cases with the z given there.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_core_test;

  localparam int RAND_PHASES    = 7;
  localparam int PHASE_PIXELS   = 150;
  localparam int MAX_WAIT       = 13;
  localparam int PIPE_FLUSH     = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } world_point_t;

  typedef struct {
    int          setting;
    logic [63:0] word;
    bit          typed;   // z_exp holds the answer, x and y are zero
    logic [31:0] z_exp;
  } pixel_case_t;

  logic         clk;
  logic         rst_n;
  // pixel_col[11:0], pixel_row[23:12], depth_raw[39:24],
  // blue_in[47:40], green_in[55:48], red_in[63:56]
  logic [63:0]  in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  // point_x[31:0], point_y[63:32], point_z[95:64],
  // blue_out[103:96], green_out[111:104], red_out[119:112]
  logic [119:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [5:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  dpw_pkg::cfg_t pose_regs;          // what the core's registers hold
  dpw_pkg::cfg_t corner_settings [5];
  pixel_case_t   pixel_cases [$];
  world_point_t  pending_points [$];

  int fail_count    = 0;
  int points_seen   = 0;
  int pixels_sent   = 0;
  int setting_loads = 0;
  int rx_hold       = 0;
  int quiet_cycles  = 0;
  bit rx_calm       = 1'b0;
  bit tx_calm       = 1'b0;

  depth_pixel_to_world_point_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  // round(t * b / 2^28), ties away from zero, split in 32-bit halves
  function automatic logic signed [63:0] recip_scale(input logic signed [63:0] t,
                                                     input logic [31:0] b);
    logic [63:0] m, hi, lo, b64, r;
    m   = t[63] ? -t : t;
    hi  = m >> 32;
    lo  = {32'd0, m[31:0]};
    b64 = {32'd0, b};
    r   = ((hi * b64) << 4) + ((lo * b64 + 64'd134217728) >> 28);
    return t[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] clamp_cam(input logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = 64'sd1 <<< (dpw_pkg::CAM_W - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one output axis: R row dot point plus translation, Q.30 -> Q16.16
  function automatic logic [31:0] pose_axis(input logic [47:0] r,
                                            input logic signed [63:0] x,
                                            input logic signed [63:0] y,
                                            input logic signed [63:0] z,
                                            input logic [31:0] t);
    logic signed [67:0] ex, ey, ez, tt, acc;
    ex  = $signed(r[15:0]);
    ey  = $signed(r[31:16]);
    ez  = $signed(r[47:32]);
    tt  = $signed(t);
    acc = ex * x + ey * y + ez * z + (tt <<< 14) + 68'sd8192;
    acc = acc >>> 14;
    if (acc > 68'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -68'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  // nonzero depth only; zero-depth pixels are filtered by the caller
  function automatic world_point_t project_pixel(input dpw_pkg::cfg_t c,
                                                 input logic [63:0] w);
    world_point_t p;
    logic [63:0] zq;
    logic signed [63:0] cz, dx, dy, cxw, cyw;
    zq  = {48'd0, w[39:24]} * {32'd0, c.depth_scale_recip} + 64'd128;
    cz  = $signed(zq >> 8);
    dx  = $signed({48'd0, w[11:0], 4'd0}) - $signed({48'd0, c.principal_point[15:0]});
    dy  = $signed({48'd0, w[23:12], 4'd0}) - $signed({48'd0, c.principal_point[31:16]});
    cxw = clamp_cam(recip_scale(dx * cz, c.focal_recip[31:0]));
    cyw = clamp_cam(recip_scale(dy * cz, c.focal_recip[63:32]));
    cz  = clamp_cam(cz);
    p.px    = pose_axis(c.rot_row[0], cxw, cyw, cz, c.translation_xy[31:0]);
    p.py    = pose_axis(c.rot_row[1], cxw, cyw, cz, c.translation_xy[63:32]);
    p.pz    = pose_axis(c.rot_row[2], cxw, cyw, cz, c.translation_z);
    p.blue  = w[47:40];
    p.green = w[55:48];
    p.red   = w[63:56];
    return p;
  endfunction

  // ------------------------------------------------------------ stimulus

  function automatic logic [63:0] pix(input logic [11:0] col, input logic [11:0] row,
                                      input logic [15:0] dep, input logic [7:0] b,
                                      input logic [7:0] g, input logic [7:0] r);
    return {r, g, b, dep, row, col};
  endfunction

  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'h7FFF;
    endcase
  endfunction

  function automatic logic [31:0] corner32();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // rotation entry within -1.0 .. +1.0
  function automatic logic [15:0] rot_entry();
    logic [31:0] v;
    v = $urandom_range(0, 32768) - 32'd16384;
    return v[15:0];
  endfunction

  function automatic dpw_pkg::cfg_t draw_setting(input int mode);
    dpw_pkg::cfg_t c;
    logic [63:0] wide;
    case (mode)
      0: begin // plausible camera and pose
        c.depth_scale_recip = $urandom_range(1, 32'h0100_0000);
        c.principal_point   = ($urandom_range(0, 16384) << 16) | $urandom_range(0, 16384);
        c.focal_recip       = {$urandom_range(1, 32'h0010_0000),
                               $urandom_range(1, 32'h0010_0000)};
        for (int k = 0; k < 3; k++) c.rot_row[k] = {rot_entry(), rot_entry(), rot_entry()};
        c.translation_xy    = {$urandom, $urandom};
        c.translation_z     = $urandom;
      end
      1: begin // anything goes
        c.depth_scale_recip = $urandom;
        c.principal_point   = $urandom;
        c.focal_recip       = {$urandom, $urandom};
        for (int k = 0; k < 3; k++) begin
          wide         = {$urandom, $urandom};
          c.rot_row[k] = wide[47:0];
        end
        c.translation_xy    = {$urandom, $urandom};
        c.translation_z     = $urandom;
      end
      default: begin // every subfield at a corner
        c.depth_scale_recip = corner32();
        c.principal_point   = {corner16(), corner16()};
        c.focal_recip       = {corner32(), corner32()};
        for (int k = 0; k < 3; k++) c.rot_row[k] = {corner16(), corner16(), corner16()};
        c.translation_xy    = {corner32(), corner32()};
        c.translation_z     = corner32();
      end
    endcase
    return c;
  endfunction

  task automatic add_case(input int s, input logic [63:0] w, input bit typed,
                          input logic [31:0] z_exp);
    pixel_case_t pc;
    pc.setting = s;
    pc.word    = w;
    pc.typed   = typed;
    pc.z_exp   = z_exp;
    pixel_cases.insert(pixel_cases.size(), pc);
  endtask

  // APB write; psel stays up across back-to-back writes
  task automatic write_reg(input dpw_pkg::cfg_reg_t idx, input logic [63:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  // drain the core, then rewrite every register; upper bits of the narrower ones carry junk
  task automatic load_setting(input dpw_pkg::cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
    write_reg(dpw_pkg::REG_DEPTH_SCALE_RECIP, {junk, c.depth_scale_recip});
    write_reg(dpw_pkg::REG_PRINCIPAL_POINT, {~junk, c.principal_point});
    write_reg(dpw_pkg::REG_FOCAL_RECIP, c.focal_recip);
    write_reg(dpw_pkg::REG_ROT_ROW0, {junk[15:0], c.rot_row[0]});
    write_reg(dpw_pkg::REG_ROT_ROW1, {junk[31:16], c.rot_row[1]});
    write_reg(dpw_pkg::REG_ROT_ROW2, {~junk[15:0], c.rot_row[2]});
    write_reg(dpw_pkg::REG_TRANSLATION_XY, c.translation_xy);
    write_reg(dpw_pkg::REG_TRANSLATION_Z, {junk, c.translation_z});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    pose_regs = c;
    setting_loads++;
  endtask

  // valid is only lowered when a gap is drawn, so back-to-back words keep it up
  task automatic push_pixel(input logic [63:0] w, input bit predict);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    if (predict && w[39:24] != 16'd0)
      pending_points.insert(pending_points.size(), project_pixel(pose_regs, w));
  endtask

  // ------------------------------------------------------------ checking

  task automatic check_point(input logic [119:0] d);
    world_point_t e;
    if (pending_points.size() == 0) begin
      $error("output word with no pixel pending: %h", d);
      fail_count++;
    end else begin
      e = pending_points.pop_front();
      points_seen++;
      if (d[31:0] !== e.px) begin
        $error("point_x expected %0d got %0d", $signed(e.px), $signed(d[31:0]));
        fail_count++;
      end
      if (d[63:32] !== e.py) begin
        $error("point_y expected %0d got %0d", $signed(e.py), $signed(d[63:32]));
        fail_count++;
      end
      if (d[95:64] !== e.pz) begin
        $error("point_z expected %0d got %0d", $signed(e.pz), $signed(d[95:64]));
        fail_count++;
      end
      if (d[103:96] !== e.blue) begin
        $error("blue_out expected %0d got %0d", e.blue, d[103:96]);
        fail_count++;
      end
      if (d[111:104] !== e.green) begin
        $error("green_out expected %0d got %0d", e.green, d[111:104]);
        fail_count++;
      end
      if (d[119:112] !== e.red) begin
        $error("red_out expected %0d got %0d", e.red, d[119:112]);
        fail_count++;
      end
    end
  endtask

  // output side: check each word, then maybe stall for a drawn stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_point(out_tdata);
      rx_hold = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles < WATCHDOG_LIMIT) begin
      quiet_cycles++;
    end else begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main

  initial begin
    world_point_t typed_pt;
    logic [31:0]  a, c32;
    logic [15:0]  dep;
    int           hold_at;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;

    corner_settings[0].depth_scale_recip = dpw_pkg::RST_DEPTH_SCALE_RECIP;
    corner_settings[0].principal_point   = dpw_pkg::RST_PRINCIPAL_POINT;
    corner_settings[0].focal_recip       = dpw_pkg::RST_FOCAL_RECIP;
    corner_settings[0].rot_row[0]        = dpw_pkg::RST_ROT_ROW0;
    corner_settings[0].rot_row[1]        = dpw_pkg::RST_ROT_ROW1;
    corner_settings[0].rot_row[2]        = dpw_pkg::RST_ROT_ROW2;
    corner_settings[0].translation_xy    = dpw_pkg::RST_TRANSLATION_XY;
    corner_settings[0].translation_z     = dpw_pkg::RST_TRANSLATION_Z;

    // everything at its positive maximum
    corner_settings[1].depth_scale_recip = '1;
    corner_settings[1].principal_point   = '1;
    corner_settings[1].focal_recip       = '1;
    for (int k = 0; k < 3; k++) corner_settings[1].rot_row[k] = {3{16'h7FFF}};
    corner_settings[1].translation_xy    = {2{32'h7FFF_FFFF}};
    corner_settings[1].translation_z     = 32'h7FFF_FFFF;

    // negative rotation and translation, no principal point
    corner_settings[2].depth_scale_recip = '1;
    corner_settings[2].principal_point   = '0;
    corner_settings[2].focal_recip       = '1;
    for (int k = 0; k < 3; k++) corner_settings[2].rot_row[k] = {3{16'h8000}};
    corner_settings[2].translation_xy    = {2{32'h8000_0000}};
    corner_settings[2].translation_z     = 32'h8000_0000;

    // VGA camera, f = 525, turned 90 degrees about z
    corner_settings[3].depth_scale_recip = 32'd16777;
    corner_settings[3].principal_point   = {16'd3840, 16'd5120};
    corner_settings[3].focal_recip       = {32'd31957, 32'd31957};
    corner_settings[3].rot_row[0]        = 48'h0000_C000_0000;
    corner_settings[3].rot_row[1]        = 48'h0000_0000_4000;
    corner_settings[3].rot_row[2]        = 48'h4000_0000_0000;
    corner_settings[3].translation_xy    = 64'hFFFE_8000_0002_4000;
    corner_settings[3].translation_z     = 32'h0001_0000;

    corner_settings[4] = '0;

    pose_regs = corner_settings[0];

    // reset registers: identity pose, 1/f = 0, so x = y = 0 and z = depth/1000
    add_case(0, pix(0, 0, 0, 0, 0, 0), 1, 0);
    add_case(0, pix(4095, 4095, 0, 255, 255, 255), 1, 0);
    add_case(0, pix(0, 0, 1, 0, 0, 0), 1, 32'd66);
    add_case(0, pix(4095, 4095, 1000, 255, 255, 255), 1, 32'd65535);
    add_case(0, pix(123, 456, 16'hFFFF, 8'h5A, 8'hA5, 8'h3C), 1, 32'd4294846);
    add_case(0, pix(2730, 1365, 16'h8000, 8'h81, 8'h42, 8'h18), 0, 0);
    // saturating camera and world coordinates
    add_case(1, pix(0, 0, 16'hFFFF, 8'h01, 8'h02, 8'h04), 0, 0);
    add_case(1, pix(4095, 4095, 16'hFFFF, 8'hFE, 8'hFD, 8'hFB), 0, 0);
    add_case(1, pix(4095, 0, 1, 8'h10, 8'h20, 8'h40), 0, 0);
    add_case(1, pix(2048, 4095, 16'h8000, 8'h7F, 8'h80, 8'hFF), 0, 0);
    add_case(1, pix(0, 0, 0, 8'hFF, 8'h00, 8'hFF), 0, 0);
    add_case(2, pix(0, 0, 16'hFFFF, 8'hAA, 8'h55, 8'hAA), 0, 0);
    add_case(2, pix(4095, 4095, 16'hFFFF, 8'h55, 8'hAA, 8'h55), 0, 0);
    add_case(2, pix(1, 1, 1, 8'h00, 8'hFF, 8'h00), 0, 0);
    // pixels on either side of the principal point give negative and positive offsets
    add_case(3, pix(320, 240, 1000, 8'h11, 8'h22, 8'h33), 0, 0);
    add_case(3, pix(0, 0, 1500, 8'h44, 8'h55, 8'h66), 0, 0);
    add_case(3, pix(639, 479, 800, 8'h77, 8'h88, 8'h99), 0, 0);
    add_case(3, pix(100, 400, 0, 8'hCC, 8'hDD, 8'hEE), 0, 0);
    add_case(4, pix(4095, 4095, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), 0, 0);
    add_case(4, pix(7, 9, 300, 8'h12, 8'h34, 8'h56), 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (pixel_cases[i]) begin
      if (i > 0 && pixel_cases[i].setting != pixel_cases[i-1].setting)
        load_setting(corner_settings[pixel_cases[i].setting]);
      push_pixel(pixel_cases[i].word, !pixel_cases[i].typed);
      if (pixel_cases[i].typed && pixel_cases[i].word[39:24] != 16'd0) begin
        typed_pt.px    = 32'd0;
        typed_pt.py    = 32'd0;
        typed_pt.pz    = pixel_cases[i].z_exp;
        typed_pt.blue  = pixel_cases[i].word[47:40];
        typed_pt.green = pixel_cases[i].word[55:48];
        typed_pt.red   = pixel_cases[i].word[63:56];
        pending_points.insert(pending_points.size(), typed_pt);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      load_setting(draw_setting(ph % 3));
      tx_calm = (ph == 3);  // one phase runs at full rate on both sides
      rx_calm = (ph == 3);
      hold_at = $urandom_range(10, PHASE_PIXELS - 10);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        if (k == hold_at) begin
          // let the core run dry before going on
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending_points.size() != 0) @(posedge clk);
        end
        a   = $urandom;
        c32 = $urandom;
        case ($urandom_range(0, 7))
          0:       dep = 16'h0000;
          1:       dep = 16'hFFFF;
          2:       dep = 16'h0001;
          3:       dep = {8'd0, a[31:24]};
          default: dep = c32[31:16] ^ a[31:16];
        endcase
        push_pixel({c32[23:0], dep, a[23:0]}, 1'b1);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);

    $display("%0d pixels over %0d register settings, %0d world points checked, %0d errors",
             pixels_sent, setting_loads + 1, points_seen, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
